// ===== rtl/two_ray_vergence_midpoint_core_defines.svh =====
// Assertion macros used by the top module of the ray midpoint core.
`ifndef TWO_RAY_VERGENCE_MIDPOINT_CORE_DEFINES_SVH
`define TWO_RAY_VERGENCE_MIDPOINT_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TRVM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TRVM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/trvm_pkg.sv =====
package trvm_pkg;

   localparam int CW    = 32;            // coordinate width
   localparam int FB    = 16;            // fraction bits
   localparam int PW    = 32;            // slice width of the wide multiplies
   localparam int XW    = CW + 1;        // narrow multiply operand
   localparam int SW_PP = XW + PW + 1;   // one partial product
   localparam int NW    = 2 * CW + 1;    // n = gL x gR
   localparam int AW    = 3 * CW + 2;    // gL x n and gR x n
   localparam int DEW   = 4 * CW + 4;    // denominators
   localparam int NUW   = 4 * CW + 6;    // numerators
   localparam int QW    = NUW + FB;      // quotient magnitude
   localparam int TW    = QW + 1;        // signed ray parameter
   localparam int MW    = CW + TW + 2;   // sum of both closest points
   localparam int HW    = MW - FB - 1;   // midpoint before clipping
   localparam int NCN   = (NW + PW - 1) / PW;
   localparam int NCA   = (AW + PW - 1) / PW;
   localparam int NCT   = (TW + PW - 1) / PW;
   localparam int PADW  = NCT * PW;
   localparam logic [MW-1:0] TRUNC_BIAS = (MW'(1) << (FB + 1)) - MW'(1);

   typedef struct packed {
      logic [2:0][CW-1:0] er;
      logic [2:0][CW-1:0] gr;
      logic [2:0][CW-1:0] el;
      logic [2:0][CW-1:0] gl;
   } ray_type;

   typedef struct packed {
      ray_type        ray;
      logic [NUW-1:0] num_r;
      logic [DEW-1:0] den_r;
      logic [NUW-1:0] num_l;
      logic [DEW-1:0] den_l;
   } geo_type;

   typedef struct packed {
      logic [DEW-1:0] dvs;
      logic [DEW-1:0] rem;
      logic [QW-1:0]  nq;
      logic           neg;
   } lane_type;

   typedef struct packed {
      ray_type  ray;
      lane_type r;
      lane_type l;
      logic     parallel;
   } dstage_type;

   typedef struct packed {
      logic [2:0][CW-1:0] mid;
      logic               parallel;
      logic               sat;
   } mid_type;

   // One slice of a wide signed operand; only the top slice carries the sign.
   function automatic logic signed [PW:0] slice_of(input logic [PADW-1:0] y,
                                                   input int k, input int nch);
      logic [PW-1:0] s;
      s = y[k*PW +: PW];
      if (k == nch - 1) return {s[PW-1], s};
      return {1'b0, s};
   endfunction

   function automatic logic signed [SW_PP-1:0] pp_mul(input logic signed [XW-1:0] x,
                                                      input logic signed [PW:0] c);
      logic signed [SW_PP-1:0] p;
      p = x * c;
      return p;
   endfunction

endpackage

// ===== rtl/trvm_ifs.sv =====
interface trvm_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [trvm_pkg::CW-1:0] right_origin_x;
   logic signed [trvm_pkg::CW-1:0] right_origin_y;
   logic signed [trvm_pkg::CW-1:0] right_origin_z;
   logic signed [trvm_pkg::CW-1:0] right_dir_x;
   logic signed [trvm_pkg::CW-1:0] right_dir_y;
   logic signed [trvm_pkg::CW-1:0] right_dir_z;
   logic signed [trvm_pkg::CW-1:0] left_origin_x;
   logic signed [trvm_pkg::CW-1:0] left_origin_y;
   logic signed [trvm_pkg::CW-1:0] left_origin_z;
   logic signed [trvm_pkg::CW-1:0] left_dir_x;
   logic signed [trvm_pkg::CW-1:0] left_dir_y;
   logic signed [trvm_pkg::CW-1:0] left_dir_z;

   modport source (output valid, right_origin_x, right_origin_y, right_origin_z,
                   right_dir_x, right_dir_y, right_dir_z, left_origin_x,
                   left_origin_y, left_origin_z, left_dir_x, left_dir_y,
                   left_dir_z, input ready);
   modport sink (input valid, right_origin_x, right_origin_y, right_origin_z,
                 right_dir_x, right_dir_y, right_dir_z, left_origin_x,
                 left_origin_y, left_origin_z, left_dir_x, left_dir_y,
                 left_dir_z, output ready);
endinterface

interface trvm_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [trvm_pkg::CW-1:0] mid_x;
   logic signed [trvm_pkg::CW-1:0] mid_y;
   logic signed [trvm_pkg::CW-1:0] mid_z;
   logic                              parallel_flag;
   logic                              saturated_flag;

   modport source (output valid, mid_x, mid_y, mid_z, parallel_flag, saturated_flag,
                   input ready);
   modport sink (input valid, mid_x, mid_y, mid_z, parallel_flag, saturated_flag,
                 output ready);
endinterface

// ===== rtl/trvm_geom.sv =====
module trvm_geom (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  trvm_pkg::ray_type in_ray,
   output logic              out_valid,
   output trvm_pkg::geo_type out_geo
);
   localparam int I1 [3] = '{1, 2, 0};
   localparam int I2 [3] = '{2, 0, 1};

   logic [6:0] vld_ff, vld_in;
   trvm_pkg::ray_type ray_ff [6];
   trvm_pkg::ray_type ray_in [6];

   logic signed [trvm_pkg::XW-1:0]    dif_ff [4][3];
   logic signed [trvm_pkg::XW-1:0]    dif_in [4][3];
   logic signed [2*trvm_pkg::CW-1:0]  prd_ff [6];
   logic signed [2*trvm_pkg::CW-1:0]  prd_in [6];
   logic signed [trvm_pkg::NW-1:0]    n_ff [3];
   logic signed [trvm_pkg::NW-1:0]    n_in [3];
   logic signed [trvm_pkg::SW_PP-1:0] ppa_ff [3][2][trvm_pkg::NCN];
   logic signed [trvm_pkg::SW_PP-1:0] ppa_in [3][2][trvm_pkg::NCN];
   logic signed [trvm_pkg::SW_PP-1:0] ppb_ff [3][2][trvm_pkg::NCN];
   logic signed [trvm_pkg::SW_PP-1:0] ppb_in [3][2][trvm_pkg::NCN];
   logic signed [trvm_pkg::AW-1:0]    a_ff [3];
   logic signed [trvm_pkg::AW-1:0]    a_in [3];
   logic signed [trvm_pkg::AW-1:0]    b_ff [3];
   logic signed [trvm_pkg::AW-1:0]    b_in [3];
   logic signed [trvm_pkg::SW_PP-1:0] pdr_ff [3][trvm_pkg::NCA];
   logic signed [trvm_pkg::SW_PP-1:0] pdr_in [3][trvm_pkg::NCA];
   logic signed [trvm_pkg::SW_PP-1:0] pnr_ff [3][trvm_pkg::NCA];
   logic signed [trvm_pkg::SW_PP-1:0] pnr_in [3][trvm_pkg::NCA];
   logic signed [trvm_pkg::SW_PP-1:0] pdl_ff [3][trvm_pkg::NCA];
   logic signed [trvm_pkg::SW_PP-1:0] pdl_in [3][trvm_pkg::NCA];
   logic signed [trvm_pkg::SW_PP-1:0] pnl_ff [3][trvm_pkg::NCA];
   logic signed [trvm_pkg::SW_PP-1:0] pnl_in [3][trvm_pkg::NCA];
   logic signed [trvm_pkg::DEW-1:0]   tdr_ff [3];
   logic signed [trvm_pkg::DEW-1:0]   tdr_in [3];
   logic signed [trvm_pkg::NUW-1:0]   tnr_ff [3];
   logic signed [trvm_pkg::NUW-1:0]   tnr_in [3];
   logic signed [trvm_pkg::DEW-1:0]   tdl_ff [3];
   logic signed [trvm_pkg::DEW-1:0]   tdl_in [3];
   logic signed [trvm_pkg::NUW-1:0]   tnl_ff [3];
   logic signed [trvm_pkg::NUW-1:0]   tnl_in [3];
   trvm_pkg::geo_type geo_ff, geo_in;

   assign vld_in = {vld_ff[5:0], in_valid};

   always_comb begin
      ray_in[0] = in_ray;
      for (int s = 1; s < 6; s++) ray_in[s] = ray_ff[s-1];
   end

   // Stage 1: products for n and the origin differences.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         prd_in[2*k]   = $signed(in_ray.gl[I1[k]]) * $signed(in_ray.gr[I2[k]]);
         prd_in[2*k+1] = $signed(in_ray.gl[I2[k]]) * $signed(in_ray.gr[I1[k]]);
         dif_in[0][k]  = trvm_pkg::XW'($signed(in_ray.er[k]))
                       - trvm_pkg::XW'($signed(in_ray.el[k]));
      end
      for (int s = 1; s < 4; s++) dif_in[s] = dif_ff[s-1];
   end

   // Stage 2: n = gL x gR.
   always_comb begin
      for (int k = 0; k < 3; k++)
         n_in[k] = trvm_pkg::NW'(prd_ff[2*k]) - trvm_pkg::NW'(prd_ff[2*k+1]);
   end

   // Stage 3: sliced products of gL x n and gR x n.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int c = 0; c < trvm_pkg::NCN; c++) begin
            ppa_in[k][0][c] = trvm_pkg::pp_mul(
               trvm_pkg::XW'($signed(ray_ff[1].gl[I1[k]])),
               trvm_pkg::slice_of(trvm_pkg::PADW'(n_ff[I2[k]]), c, trvm_pkg::NCN));
            ppa_in[k][1][c] = trvm_pkg::pp_mul(
               trvm_pkg::XW'($signed(ray_ff[1].gl[I2[k]])),
               trvm_pkg::slice_of(trvm_pkg::PADW'(n_ff[I1[k]]), c, trvm_pkg::NCN));
            ppb_in[k][0][c] = trvm_pkg::pp_mul(
               trvm_pkg::XW'($signed(ray_ff[1].gr[I1[k]])),
               trvm_pkg::slice_of(trvm_pkg::PADW'(n_ff[I2[k]]), c, trvm_pkg::NCN));
            ppb_in[k][1][c] = trvm_pkg::pp_mul(
               trvm_pkg::XW'($signed(ray_ff[1].gr[I2[k]])),
               trvm_pkg::slice_of(trvm_pkg::PADW'(n_ff[I1[k]]), c, trvm_pkg::NCN));
         end
      end
   end

   // Stage 4: gather the slices into gL x n and gR x n.
   always_comb begin
      logic signed [trvm_pkg::AW-1:0] sa0, sa1, sb0, sb1;
      for (int k = 0; k < 3; k++) begin
         sa0 = '0;
         sa1 = '0;
         sb0 = '0;
         sb1 = '0;
         for (int c = 0; c < trvm_pkg::NCN; c++) begin
            sa0 = sa0 + (trvm_pkg::AW'(ppa_ff[k][0][c]) <<< (c * trvm_pkg::PW));
            sa1 = sa1 + (trvm_pkg::AW'(ppa_ff[k][1][c]) <<< (c * trvm_pkg::PW));
            sb0 = sb0 + (trvm_pkg::AW'(ppb_ff[k][0][c]) <<< (c * trvm_pkg::PW));
            sb1 = sb1 + (trvm_pkg::AW'(ppb_ff[k][1][c]) <<< (c * trvm_pkg::PW));
         end
         a_in[k] = sa0 - sa1;
         b_in[k] = sb0 - sb1;
      end
   end

   // Stage 5: sliced products of the four dot products.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int c = 0; c < trvm_pkg::NCA; c++) begin
            pdr_in[k][c] = trvm_pkg::pp_mul(trvm_pkg::XW'($signed(ray_ff[3].gr[k])),
               trvm_pkg::slice_of(trvm_pkg::PADW'(a_ff[k]), c, trvm_pkg::NCA));
            pnr_in[k][c] = trvm_pkg::pp_mul(dif_ff[3][k],
               trvm_pkg::slice_of(trvm_pkg::PADW'(a_ff[k]), c, trvm_pkg::NCA));
            pdl_in[k][c] = trvm_pkg::pp_mul(trvm_pkg::XW'($signed(ray_ff[3].gl[k])),
               trvm_pkg::slice_of(trvm_pkg::PADW'(b_ff[k]), c, trvm_pkg::NCA));
            pnl_in[k][c] = trvm_pkg::pp_mul(dif_ff[3][k],
               trvm_pkg::slice_of(trvm_pkg::PADW'(b_ff[k]), c, trvm_pkg::NCA));
         end
      end
   end

   // Stage 6: gather each product term.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         tdr_in[k] = '0;
         tnr_in[k] = '0;
         tdl_in[k] = '0;
         tnl_in[k] = '0;
         for (int c = 0; c < trvm_pkg::NCA; c++) begin
            tdr_in[k] = tdr_in[k] + (trvm_pkg::DEW'(pdr_ff[k][c]) <<< (c * trvm_pkg::PW));
            tnr_in[k] = tnr_in[k] + (trvm_pkg::NUW'(pnr_ff[k][c]) <<< (c * trvm_pkg::PW));
            tdl_in[k] = tdl_in[k] + (trvm_pkg::DEW'(pdl_ff[k][c]) <<< (c * trvm_pkg::PW));
            tnl_in[k] = tnl_in[k] + (trvm_pkg::NUW'(pnl_ff[k][c]) <<< (c * trvm_pkg::PW));
         end
      end
   end

   // Stage 7: dot products. The right numerator is negated, as it uses eR-eL.
   always_comb begin
      geo_in.ray   = ray_ff[5];
      geo_in.den_r = tdr_ff[0] + tdr_ff[1] + tdr_ff[2];
      geo_in.num_r = -(tnr_ff[0] + tnr_ff[1] + tnr_ff[2]);
      geo_in.den_l = tdl_ff[0] + tdl_ff[1] + tdl_ff[2];
      geo_in.num_l = tnl_ff[0] + tnl_ff[1] + tnl_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ray_ff <= ray_in;
         dif_ff <= dif_in;
         prd_ff <= prd_in;
         n_ff   <= n_in;
         ppa_ff <= ppa_in;
         ppb_ff <= ppb_in;
         a_ff   <= a_in;
         b_ff   <= b_in;
         pdr_ff <= pdr_in;
         pnr_ff <= pnr_in;
         pdl_ff <= pdl_in;
         pnl_ff <= pnl_in;
         tdr_ff <= tdr_in;
         tnr_ff <= tnr_in;
         tdl_ff <= tdl_in;
         tnl_ff <= tnl_in;
         geo_ff <= geo_in;
      end
   end

   assign out_valid = vld_ff[6];
   assign out_geo   = geo_ff;

endmodule

// ===== rtl/trvm_div.sv =====
module trvm_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  trvm_pkg::geo_type    in_geo,
   output logic                 out_valid,
   output trvm_pkg::dstage_type out_stage
);
   logic [trvm_pkg::QW:0] vld_ff, vld_in;
   trvm_pkg::dstage_type st_ff [trvm_pkg::QW+1];
   trvm_pkg::dstage_type st_in [trvm_pkg::QW+1];

   // One restoring step: shift in the next dividend bit, subtract if it fits.
   function automatic trvm_pkg::lane_type div_step(input trvm_pkg::lane_type x);
      trvm_pkg::lane_type       y;
      logic [trvm_pkg::DEW:0] sh;
      logic [trvm_pkg::DEW:0] diff;
      y    = x;
      sh   = {x.rem, x.nq[trvm_pkg::QW-1]};
      diff = sh - {1'b0, x.dvs};
      y.nq  = {x.nq[trvm_pkg::QW-2:0], ~diff[trvm_pkg::DEW]};
      y.rem = diff[trvm_pkg::DEW] ? sh[trvm_pkg::DEW-1:0] : diff[trvm_pkg::DEW-1:0];
      return y;
   endfunction

   // Entry stage: magnitudes, quotient signs and the parallel test.
   always_comb begin
      logic [trvm_pkg::NUW-1:0] mag_nr, mag_nl;
      mag_nr = in_geo.num_r[trvm_pkg::NUW-1] ? -in_geo.num_r : in_geo.num_r;
      mag_nl = in_geo.num_l[trvm_pkg::NUW-1] ? -in_geo.num_l : in_geo.num_l;
      st_in[0].ray      = in_geo.ray;
      st_in[0].parallel = (in_geo.den_r == '0) || (in_geo.den_l == '0);
      st_in[0].r.dvs = in_geo.den_r[trvm_pkg::DEW-1] ? -in_geo.den_r : in_geo.den_r;
      st_in[0].l.dvs = in_geo.den_l[trvm_pkg::DEW-1] ? -in_geo.den_l : in_geo.den_l;
      st_in[0].r.rem = '0;
      st_in[0].l.rem = '0;
      st_in[0].r.nq  = trvm_pkg::QW'(mag_nr) << trvm_pkg::FB;
      st_in[0].l.nq  = trvm_pkg::QW'(mag_nl) << trvm_pkg::FB;
      st_in[0].r.neg = in_geo.num_r[trvm_pkg::NUW-1] ^ in_geo.den_r[trvm_pkg::DEW-1];
      st_in[0].l.neg = in_geo.num_l[trvm_pkg::NUW-1] ^ in_geo.den_l[trvm_pkg::DEW-1];
      for (int i = 0; i < trvm_pkg::QW; i++) begin
         st_in[i+1]   = st_ff[i];
         st_in[i+1].r = div_step(st_ff[i].r);
         st_in[i+1].l = div_step(st_ff[i].l);
      end
   end

   assign vld_in = {vld_ff[trvm_pkg::QW-1:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st_ff <= st_in;
      end
   end

   assign out_valid = vld_ff[trvm_pkg::QW];
   assign out_stage = st_ff[trvm_pkg::QW];

endmodule

// ===== rtl/trvm_mid.sv =====
module trvm_mid (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  trvm_pkg::dstage_type in_stage,
   output logic                 out_valid,
   output trvm_pkg::mid_type    out_mid
);
   logic [4:0] vld_ff, vld_in;
   logic [3:0] par_ff, par_in;
   trvm_pkg::ray_type ray_ff, ray_in;

   logic signed [trvm_pkg::TW-1:0]    tr_ff, tr_in, tl_ff, tl_in;
   logic signed [trvm_pkg::SW_PP-1:0] ppr_ff [3][trvm_pkg::NCT];
   logic signed [trvm_pkg::SW_PP-1:0] ppr_in [3][trvm_pkg::NCT];
   logic signed [trvm_pkg::SW_PP-1:0] ppl_ff [3][trvm_pkg::NCT];
   logic signed [trvm_pkg::SW_PP-1:0] ppl_in [3][trvm_pkg::NCT];
   logic signed [trvm_pkg::XW-1:0]    es_ff [2][3];
   logic signed [trvm_pkg::XW-1:0]    es_in [2][3];
   logic signed [trvm_pkg::MW-1:0]    mr_ff [3], mr_in [3], ml_ff [3], ml_in [3];
   logic signed [trvm_pkg::MW-1:0]    s_ff [3], s_in [3];
   trvm_pkg::mid_type res_ff, res_in;

   assign vld_in = {vld_ff[3:0], in_valid};
   assign par_in = {par_ff[2:0], in_stage.parallel};
   assign ray_in = in_stage.ray;

   // Stage 1: signed ray parameters.
   always_comb begin
      tr_in = in_stage.r.neg ? -$signed({1'b0, in_stage.r.nq}) : $signed({1'b0, in_stage.r.nq});
      tl_in = in_stage.l.neg ? -$signed({1'b0, in_stage.l.nq}) : $signed({1'b0, in_stage.l.nq});
   end

   // Stage 2: sliced products of the directions with the parameters.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int c = 0; c < trvm_pkg::NCT; c++) begin
            ppr_in[k][c] = trvm_pkg::pp_mul(trvm_pkg::XW'($signed(ray_ff.gr[k])),
               trvm_pkg::slice_of(trvm_pkg::PADW'(tr_ff), c, trvm_pkg::NCT));
            ppl_in[k][c] = trvm_pkg::pp_mul(trvm_pkg::XW'($signed(ray_ff.gl[k])),
               trvm_pkg::slice_of(trvm_pkg::PADW'(tl_ff), c, trvm_pkg::NCT));
         end
         es_in[0][k] = trvm_pkg::XW'($signed(ray_ff.er[k]))
                     + trvm_pkg::XW'($signed(ray_ff.el[k]));
      end
      es_in[1] = es_ff[0];
   end

   // Stage 3: gather the slices.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         mr_in[k] = '0;
         ml_in[k] = '0;
         for (int c = 0; c < trvm_pkg::NCT; c++) begin
            mr_in[k] = mr_in[k] + (trvm_pkg::MW'(ppr_ff[k][c]) <<< (c * trvm_pkg::PW));
            ml_in[k] = ml_in[k] + (trvm_pkg::MW'(ppl_ff[k][c]) <<< (c * trvm_pkg::PW));
         end
      end
   end

   // Stage 4: sum of both closest points, scaled by two to the fraction bits.
   always_comb begin
      for (int k = 0; k < 3; k++)
         s_in[k] = mr_ff[k] + ml_ff[k] + (trvm_pkg::MW'(es_ff[1][k]) <<< trvm_pkg::FB);
   end

   // Stage 5: halve and rescale with truncation toward zero, then clip.
   always_comb begin
      logic signed [trvm_pkg::MW-1:0] biased;
      logic signed [trvm_pkg::HW-1:0] h;
      logic                           over, under;
      res_in.sat      = 1'b0;
      res_in.parallel = par_ff[3];
      for (int k = 0; k < 3; k++) begin
         biased = s_ff[k] + (s_ff[k][trvm_pkg::MW-1] ? trvm_pkg::TRUNC_BIAS : '0);
         h      = trvm_pkg::HW'(biased >>> (trvm_pkg::FB + 1));
         over   = !h[trvm_pkg::HW-1] && (|h[trvm_pkg::HW-2:trvm_pkg::CW-1]);
         under  = h[trvm_pkg::HW-1] && !(&h[trvm_pkg::HW-2:trvm_pkg::CW-1]);
         if (par_ff[3]) begin
            res_in.mid[k] = '0;
         end else if (over) begin
            res_in.mid[k] = {1'b0, {(trvm_pkg::CW-1){1'b1}}};
            res_in.sat    = 1'b1;
         end else if (under) begin
            res_in.mid[k] = {1'b1, {(trvm_pkg::CW-1){1'b0}}};
            res_in.sat    = 1'b1;
         end else begin
            res_in.mid[k] = h[trvm_pkg::CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         par_ff <= par_in;
         ray_ff <= ray_in;
         tr_ff  <= tr_in;
         tl_ff  <= tl_in;
         ppr_ff <= ppr_in;
         ppl_ff <= ppl_in;
         es_ff  <= es_in;
         mr_ff  <= mr_in;
         ml_ff  <= ml_in;
         s_ff   <= s_in;
         res_ff <= res_in;
      end
   end

   assign out_valid = vld_ff[4];
   assign out_mid   = res_ff;

endmodule

// ===== rtl/two_ray_vergence_midpoint_core.sv =====
// Channel   Dir  Handshake     Word
// req_chan  in   valid/ready   right and left ray: origin and direction, Q16.16
// rsp_chan  out  valid/ready   midpoint x/y/z Q16.16, parallel_flag, saturated_flag
//
// One word enters per cycle unless the skid register holds a word. The path runs through
// 7 stages of cross and dot products, a one-bit-per-stage divider of QW + 1 stages,
// 5 stages of final products, averaging and clipping, then the output register.
// Reset is synchronous and clears only the valid bits; there is no clearing pass.
// When the output stalls, the one word in flight drops into a skid register and
// req_chan.ready falls in the next cycle; nothing is lost or repeated.
`include "two_ray_vergence_midpoint_core_defines.svh"

module two_ray_vergence_midpoint_core (
   input  logic       clock,
   input  logic       reset,
   trvm_req_if.sink   req_chan,
   trvm_rsp_if.source rsp_chan
);
   trvm_pkg::ray_type    in_ray;
   trvm_pkg::geo_type    geo;
   trvm_pkg::dstage_type dst;
   trvm_pkg::mid_type    pipe_mid;
   logic                 geo_valid, dst_valid, pipe_valid;
   logic                 advance, consume, take_out;

   logic              out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   trvm_pkg::mid_type out_ff, out_in, skid_ff, skid_in;

   // Pack the request word. Index 0 is x, 1 is y, 2 is z.
   always_comb begin
      in_ray.er[0] = req_chan.right_origin_x;
      in_ray.er[1] = req_chan.right_origin_y;
      in_ray.er[2] = req_chan.right_origin_z;
      in_ray.gr[0] = req_chan.right_dir_x;
      in_ray.gr[1] = req_chan.right_dir_y;
      in_ray.gr[2] = req_chan.right_dir_z;
      in_ray.el[0] = req_chan.left_origin_x;
      in_ray.el[1] = req_chan.left_origin_y;
      in_ray.el[2] = req_chan.left_origin_z;
      in_ray.gl[0] = req_chan.left_dir_x;
      in_ray.gl[1] = req_chan.left_dir_y;
      in_ray.gl[2] = req_chan.left_dir_z;
   end

   // The whole pipeline moves together; it freezes only while the skid
   // register holds a word, which keeps ready a plain register output.
   assign advance        = !skid_valid_ff;
   assign req_chan.ready = advance;

   trvm_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_chan.valid),
      .in_ray    (in_ray),
      .out_valid (geo_valid),
      .out_geo   (geo)
   );

   trvm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (geo_valid),
      .in_geo    (geo),
      .out_valid (dst_valid),
      .out_stage (dst)
   );

   trvm_mid u_mid (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (dst_valid),
      .in_stage  (dst),
      .out_valid (pipe_valid),
      .out_mid   (pipe_mid)
   );

   // A word leaves the last stage whenever the pipeline advances. It goes to
   // the output register if that is free or being drained, else to the skid.
   assign consume  = advance && pipe_valid;
   assign take_out = !out_valid_ff || rsp_chan.ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (take_out) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = consume;
            out_in       = pipe_mid;
         end
      end else if (consume) begin
         skid_valid_in = 1'b1;
         skid_in       = pipe_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.mid_x          = out_ff.mid[0];
   assign rsp_chan.mid_y          = out_ff.mid[1];
   assign rsp_chan.mid_z          = out_ff.mid[2];
   assign rsp_chan.parallel_flag  = out_ff.parallel;
   assign rsp_chan.saturated_flag = out_ff.sat;

   // The skid register is only filled behind a stalled output word.
   `TRVM_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff,
      "skid register holds a word while the output register is empty")

   // A parallel result carries a zero midpoint and no clipping.
   `TRVM_ASSERT_NOW(a_parallel_zero, clock, reset, out_valid_ff && out_ff.parallel,
      (out_ff.mid == '0) && !out_ff.sat, "parallel result is not zero")

   // The skid word stays until the output register drains.
   `TRVM_ASSERT_NEXT(a_skid_holds, clock, reset, skid_valid_ff && !rsp_chan.ready,
      skid_valid_ff, "skid word dropped while output stalled")

endmodule
